/* rtl/dcc_pkg.sv */
// shared types and constants for the defective clique counter engine
// no dependencies; imported by dcc_update and the top level
`default_nettype none

package dcc_pkg;

	localparam int CNT_W = 9;
	localparam int TOT_W = 16;

	localparam logic [CNT_W-1:0] COUNT_CAP = 9'd256;
	localparam logic [TOT_W-1:0] TOTAL_MAX = 16'hFFFF;

	// operation codes
	localparam logic [3:0] FN_LOAD   = 4'd0;
	localparam logic [3:0] FN_CLEAR  = 4'd1;
	localparam logic [3:0] FN_INIT   = 4'd2;
	localparam logic [3:0] FN_ADD    = 4'd3;
	localparam logic [3:0] FN_BUMP   = 4'd4;
	localparam logic [3:0] FN_DROP   = 4'd5;
	localparam logic [3:0] FN_REMOVE = 4'd6;
	localparam logic [3:0] FN_CHECK  = 4'd7;
	localparam logic [3:0] FN_PAIR   = 4'd8;

	typedef struct packed {
		logic [3:0] func;
		logic [7:0] vertex_a;
		logic [7:0] vertex_b;
		logic       edge_bit;
	} dcc_in_t;

	typedef struct packed {
		logic             fits;
		logic [TOT_W-1:0] missing_total;
		logic [CNT_W-1:0] vertex_count;
	} dcc_out_t;

	// operands resolved after the memory read, with forwarding applied
	typedef struct packed {
		logic             a_ok;
		logic             b_ok;
		logic             adj_bit;
		logic [CNT_W-1:0] cnt_a;
		logic [CNT_W-1:0] cnt_b;
		logic [TOT_W-1:0] total;
		logic [TOT_W-1:0] max_missing;
	} dcc_opnd_t;

	// write-back and result of one operation
	typedef struct packed {
		logic             adj_we;
		logic             cnt_we;
		logic [CNT_W-1:0] cnt_wdata;
		logic [TOT_W-1:0] total_next;
		dcc_out_t         result;
	} dcc_upd_t;

endpackage

`default_nettype wire

/* rtl/dcc_update.sv */
// modify step of the read-modify-write: saturating counts, total and fit tests
// depends on dcc_pkg
`default_nettype none

module dcc_update import dcc_pkg::*; (
	input  dcc_in_t   op,
	input  dcc_opnd_t opnd,
	output dcc_upd_t  upd
);

	logic [TOT_W:0]   add_sum;
	logic [TOT_W:0]   chk_sum;
	logic [TOT_W-1:0] cnt_b_ext;

	assign cnt_b_ext = TOT_W'(opnd.cnt_b);
	assign add_sum   = {1'b0, opnd.total} + {1'b0, cnt_b_ext};
	assign chk_sum   = {1'b0, opnd.total} + (TOT_W + 1)'(opnd.cnt_a);

	always_comb begin
		upd            = '0;
		upd.total_next = opnd.total;
		upd.cnt_wdata  = opnd.cnt_a;
		unique case (op.func)
			FN_LOAD: begin
				upd.adj_we = opnd.a_ok && opnd.b_ok;
			end
			FN_CLEAR: begin
				upd.total_next = '0;
			end
			FN_INIT: begin
				upd.cnt_we    = opnd.a_ok;
				upd.cnt_wdata = CNT_W'(!opnd.adj_bit);
			end
			FN_ADD: begin
				upd.total_next = add_sum[TOT_W] ? TOTAL_MAX : add_sum[TOT_W-1:0];
			end
			FN_BUMP: begin
				upd.cnt_we    = opnd.a_ok && !opnd.adj_bit;
				upd.cnt_wdata = (opnd.cnt_a >= COUNT_CAP) ? COUNT_CAP
				                                          : opnd.cnt_a + 1'b1;
			end
			FN_DROP: begin
				upd.cnt_we    = opnd.a_ok && !opnd.adj_bit;
				upd.cnt_wdata = (opnd.cnt_a == '0) ? '0 : opnd.cnt_a - 1'b1;
			end
			FN_REMOVE: begin
				upd.total_next = (opnd.total >= cnt_b_ext) ? opnd.total - cnt_b_ext : '0;
			end
			FN_CHECK: begin
				upd.result.fits = (chk_sum <= {1'b0, opnd.max_missing});
			end
			FN_PAIR: begin
				upd.result.fits = (opnd.max_missing != '0) || opnd.adj_bit;
			end
			default: begin
			end
		endcase
		upd.result.missing_total = upd.total_next;
		// count of vertex_a after the operation, zero when out of range
		upd.result.vertex_count  = upd.cnt_we ? upd.cnt_wdata : opnd.cnt_a;
	end

endmodule

`default_nettype wire

/* rtl/defective_clique_counter_engine_core.sv */
// top level of the defective clique counter engine: adjacency and count memories,
// read stage, forwarding, output register and assertions
// depends on dcc_pkg and dcc_update
`default_nettype none

// usage
// - input channel: in_valid / in_stall / in_word; a word is taken at a rising edge
//   with in_valid high and in_stall low; every word gives exactly one result word
// - output channel: out_valid / out_stall / out_word, one registered result word
// - cfg_wr_en / cfg_wr_data write max_missing; write only while the block is idle
// - a word taken at one edge reads both memories there, is modified and written
//   back when the stage advances, its result entering out_word at that same edge
// - throughput: one word per cycle unless stalled, set by the single
//   read-modify-write stage on the count memory; a write that lands on the edge
//   of the next read is forwarded, so back-to-back words on the same vertex need
//   no bubble
// - when out_stall holds a waiting result, the stage behind it keeps its word
//   and in_stall rises until the output register empties
// - reset clears the total, max_missing and all valid flags; the adjacency and
//   count memories are not cleared and must be loaded before being read,
//   so there is no clearing pass after reset
module defective_clique_counter_engine_core import dcc_pkg::*; #(
	parameter int NUM_VERTICES = 256
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output      logic             in_stall,
	input  wire dcc_in_t          in_word,
	output      logic             out_valid,
	input  wire logic             out_stall,
	output      dcc_out_t         out_word,
	input  wire logic             cfg_wr_en,
	input  wire logic [TOT_W-1:0] cfg_wr_data
);

	localparam int VW = $clog2(NUM_VERTICES);

	// memories, no reset: contents undefined until written
	logic             adj_mem [2**(2*VW)];
	logic [CNT_W-1:0] cnt_mem [2**VW];

	// handshake and control
	logic in_acc;
	logic s1_adv;
	logic s1_valid_q;
	logic out_valid_q;

	// architectural registers
	logic [TOT_W-1:0] total_q;
	logic [TOT_W-1:0] max_missing_q;

	// incoming word decode
	logic [VW-1:0] a_ix;
	logic [VW-1:0] b_ix;
	logic          a_ok;
	logic          b_ok;

	// read stage
	dcc_in_t          op_s1;
	logic [VW-1:0]    a_ix_s1;
	logic [VW-1:0]    b_ix_s1;
	logic             a_ok_s1;
	logic             b_ok_s1;
	logic             adj_rd_s1;
	logic [CNT_W-1:0] cnt_a_rd_s1;
	logic [CNT_W-1:0] cnt_b_rd_s1;

	// write-back captured on the edge of the read, forwarded into s1
	logic             fwd_adj_hit_s1;
	logic             fwd_adj_bit_s1;
	logic             fwd_cnt_a_hit_s1;
	logic             fwd_cnt_b_hit_s1;
	logic [CNT_W-1:0] fwd_cnt_data_s1;

	logic      adj_we;
	logic      cnt_we;
	dcc_opnd_t opnd;
	dcc_upd_t  upd;
	dcc_out_t  out_word_q;

	// vertex numbers beyond the graph read as absent and drop writes
	assign a_ix = VW'(in_word.vertex_a);
	assign b_ix = VW'(in_word.vertex_b);
	assign a_ok = (32'(in_word.vertex_a) < 32'(NUM_VERTICES));
	assign b_ok = (32'(in_word.vertex_b) < 32'(NUM_VERTICES));

	// s1 moves on whenever the output register is free or being emptied
	assign s1_adv   = s1_valid_q && (!out_valid_q || !out_stall);
	assign in_stall = s1_valid_q && out_valid_q && out_stall;
	assign in_acc   = in_valid && !in_stall;

	assign adj_we = s1_adv && upd.adj_we;
	assign cnt_we = s1_adv && upd.cnt_we;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q    <= 1'b0;
			out_valid_q   <= 1'b0;
			total_q       <= '0;
			max_missing_q <= '0;
		end else begin
			if (in_acc) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
				total_q     <= upd.total_next;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr_en) begin
				max_missing_q <= cfg_wr_data;
			end
		end
	end

	// read ports and the stage payload, both loaded when a word is taken
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1       <= in_word;
			a_ix_s1     <= a_ix;
			b_ix_s1     <= b_ix;
			a_ok_s1     <= a_ok;
			b_ok_s1     <= b_ok;
			adj_rd_s1   <= adj_mem[{a_ix, b_ix}];
			cnt_a_rd_s1 <= cnt_mem[a_ix];
			cnt_b_rd_s1 <= cnt_mem[b_ix];
			// a write on this same edge is not seen by the read: keep it aside
			fwd_adj_hit_s1   <= adj_we && ({a_ix_s1, b_ix_s1} == {a_ix, b_ix});
			fwd_adj_bit_s1   <= op_s1.edge_bit;
			fwd_cnt_a_hit_s1 <= cnt_we && (a_ix_s1 == a_ix);
			fwd_cnt_b_hit_s1 <= cnt_we && (a_ix_s1 == b_ix);
			fwd_cnt_data_s1  <= upd.cnt_wdata;
		end
		if (adj_we) begin
			adj_mem[{a_ix_s1, b_ix_s1}] <= op_s1.edge_bit;
		end
		if (cnt_we) begin
			cnt_mem[a_ix_s1] <= upd.cnt_wdata;
		end
		if (s1_adv) begin
			out_word_q <= upd.result;
		end
	end

	// operand resolution with forwarding and range masking
	always_comb begin
		opnd             = '0;
		opnd.a_ok        = a_ok_s1;
		opnd.b_ok        = b_ok_s1;
		opnd.total       = total_q;
		opnd.max_missing = max_missing_q;
		opnd.adj_bit     = a_ok_s1 && b_ok_s1
		                   && (fwd_adj_hit_s1 ? fwd_adj_bit_s1 : adj_rd_s1);
		if (a_ok_s1) begin
			opnd.cnt_a = fwd_cnt_a_hit_s1 ? fwd_cnt_data_s1 : cnt_a_rd_s1;
		end
		if (b_ok_s1) begin
			opnd.cnt_b = fwd_cnt_b_hit_s1 ? fwd_cnt_data_s1 : cnt_b_rd_s1;
		end
	end

	dcc_update u_update (
		.op   (op_s1),
		.opnd (opnd),
		.upd  (upd)
	);

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	// the input side only waits behind a held stage
	a_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> s1_valid_q)
		else $error("input stalled with an empty stage");

	// the total moves only when a word leaves the stage
	a_total_only_on_adv: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_adv |=> $stable(total_q))
		else $error("total changed without an operation");

	// a word leaving the stage always lands in the output register
	a_adv_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv |=> out_valid_q)
		else $error("result lost after stage advance");

	// memory writes come only from an advancing, in-range word
	a_cnt_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_we |-> (s1_valid_q && a_ok_s1 && (!out_valid_q || !out_stall)))
		else $error("count written outside an advancing in-range word");

endmodule

`default_nettype wire

/* tb/sv/defective_clique_counter_engine_core_tb.sv */
`timescale 1ns / 100ps
// self-checking testbench for defective_clique_counter_engine_core: directed, saturation,
// random and back-pressure words checked against an in-bench bookkeeping predictor
// depends on dcc_pkg and the rtl top level only
module defective_clique_counter_engine_core_tb;
	import dcc_pkg::*;

	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int HOLD_OFF_CYCLES = 60;
	localparam int SETTLE_CYCLES   = 10;
	// func codes the block leaves alone
	localparam logic [3:0] FN_SPARE_LO = 4'd9;
	localparam logic [3:0] FN_SPARE_HI = 4'd15;

	// expected result word; the count is unknown when the vertex was never initialised
	typedef struct {
		dcc_out_t word;
		bit       count_known;
	} due_t;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	dcc_in_t          in_word;
	logic             out_valid;
	logic             out_stall;
	dcc_out_t         out_word;
	logic             cfg_wr_en;
	logic [TOT_W-1:0] cfg_wr_data;

	defective_clique_counter_engine_core uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_word     (in_word),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_word    (out_word),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	// predictor copy of the engine state, indexed {vertex_a, vertex_b} for adjacency
	bit               adj_val   [65536];
	bit               adj_known [65536];
	logic [CNT_W-1:0] nn_count  [256];
	bit               nn_known  [256];
	logic [TOT_W-1:0] miss_total = '0;
	logic [TOT_W-1:0] miss_limit = '0;

	// expected result words in order of acceptance
	due_t due_results[$];

	int   faults      = 0;
	int   words_in    = 0;
	int   results_out = 0;
	int   func_tally[16];
	bit   no_idle      = 1'b0;
	bit   hold_off_req = 1'b0;
	logic [7:0] vpool[8];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// one operation of the engine applied to the predictor state
	function automatic due_t bookkeep(dcc_in_t w);
		due_t d;
		int   idx;
		int   sum;
		logic linked;
		idx    = {w.vertex_a, w.vertex_b};
		linked = adj_val[idx];
		d.word.fits = 1'b0;
		case (w.func)
		FN_LOAD: begin
			adj_val[idx]   = w.edge_bit;
			adj_known[idx] = 1'b1;
		end
		FN_CLEAR: miss_total = '0;
		FN_INIT: begin
			nn_count[w.vertex_a] = linked ? 9'd0 : 9'd1;
			nn_known[w.vertex_a] = 1'b1;
		end
		FN_ADD: begin
			// total saturates at the top when a vertex joins
			sum        = miss_total + nn_count[w.vertex_b];
			miss_total = (sum > TOTAL_MAX) ? TOTAL_MAX : sum[TOT_W-1:0];
		end
		FN_BUMP: begin
			if (!linked)
				nn_count[w.vertex_a] = (nn_count[w.vertex_a] >= COUNT_CAP) ?
					COUNT_CAP : nn_count[w.vertex_a] + 9'd1;
		end
		FN_DROP: begin
			if (!linked && nn_count[w.vertex_a] != 0)
				nn_count[w.vertex_a] = nn_count[w.vertex_a] - 9'd1;
		end
		FN_REMOVE: begin
			// total floors at zero when a vertex leaves
			if (miss_total >= nn_count[w.vertex_b])
				miss_total = miss_total - nn_count[w.vertex_b];
			else
				miss_total = '0;
		end
		FN_CHECK: d.word.fits = (int'(miss_total) + int'(nn_count[w.vertex_a])
			<= int'(miss_limit));
		FN_PAIR: d.word.fits = (miss_limit != 0) || linked;
		default: ;
		endcase
		d.word.missing_total = miss_total;
		d.word.vertex_count  = nn_count[w.vertex_a];
		d.count_known        = nn_known[w.vertex_a];
		return d;
	endfunction

	function automatic logic [7:0] pick_vertex();
		// mostly a small working set so pairs recur, sometimes any vertex
		if ($urandom_range(0, 2) == 0)
			return 8'($urandom_range(0, 255));
		return vpool[$urandom_range(0, 7)];
	endfunction

	task automatic log_mismatch(string field, logic [31:0] expv, logic [31:0] got);
		faults++;
		$error("%s: expected %0d, got %0d", field, expv, got);
	endtask

	// offer one word, hold it until taken, then record its expected result
	task automatic push_word(logic [3:0] f, logic [7:0] a, logic [7:0] b, logic e);
		dcc_in_t w;
		int      gap;
		int      r;
		w.func     = f;
		w.vertex_a = a;
		w.vertex_b = b;
		w.edge_bit = e;
		in_word  <= w;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		due_results.insert(due_results.size(), bookkeep(w));
		words_in++;
		func_tally[f]++;
		// idle gap: mostly none or short, now and then a long one
		r = $urandom_range(0, 99);
		if (no_idle || r < 55)
			gap = 0;
		else if (r < 90)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(6, 30);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// give a vertex a defined count before anything reads it
	task automatic ready_vertex(logic [7:0] v);
		if (!nn_known[v]) begin
			if (!adj_known[{v, v}])
				push_word(FN_LOAD, v, v, 1'($urandom_range(0, 1)));
			push_word(FN_INIT, v, v, 1'($urandom_range(0, 1)));
		end
	endtask

	// send an operation, first loading whatever state it would read undefined
	task automatic place(logic [3:0] f, logic [7:0] a, logic [7:0] b, logic e);
		if (f != FN_LOAD && f != FN_INIT)
			ready_vertex(a);
		if (f == FN_ADD || f == FN_REMOVE)
			ready_vertex(b);
		if ((f == FN_INIT || f == FN_BUMP || f == FN_DROP || f == FN_PAIR) &&
		    !adj_known[{a, b}])
			push_word(FN_LOAD, a, b, 1'($urandom_range(0, 1)));
		push_word(f, a, b, e);
	endtask

	task automatic random_word();
		int         r;
		logic [3:0] f;
		r = $urandom_range(0, 99);
		if (r < 10)
			f = FN_LOAD;
		else if (r < 13)
			f = FN_CLEAR;
		else if (r < 23)
			f = FN_INIT;
		else if (r < 38)
			f = FN_ADD;
		else if (r < 53)
			f = FN_BUMP;
		else if (r < 65)
			f = FN_DROP;
		else if (r < 77)
			f = FN_REMOVE;
		else if (r < 89)
			f = FN_CHECK;
		else if (r < 97)
			f = FN_PAIR;
		else
			f = 4'($urandom_range(FN_SPARE_LO, FN_SPARE_HI));
		place(f, pick_vertex(), pick_vertex(), 1'($urandom_range(0, 1)));
	endtask

	// stop offering and wait for every outstanding result word
	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (due_results.size() != 0);
	endtask

	// max_missing is only written with the engine empty
	task automatic set_limit(logic [TOT_W-1:0] v);
		wait_drained();
		repeat (2) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en  <= 1'b0;
		miss_limit = v;
	endtask

	// extremes of the vertex range, every func, floor of the total, spare codes
	task automatic test_directed();
		set_limit('0);
		place(FN_LOAD, 8'd0, 8'd0, 1'b1);
		place(FN_LOAD, 8'd255, 8'd255, 1'b0);
		place(FN_LOAD, 8'd0, 8'd255, 1'b0);
		place(FN_LOAD, 8'd255, 8'd0, 1'b1);
		place(FN_INIT, 8'd0, 8'd0, 1'b0);
		place(FN_INIT, 8'd255, 8'd255, 1'b1);
		// zero limit: a pair only fits when adjacent
		place(FN_PAIR, 8'd0, 8'd0, 1'b0);
		place(FN_PAIR, 8'd0, 8'd255, 1'b1);
		place(FN_CHECK, 8'd255, 8'd0, 1'b0);
		place(FN_CHECK, 8'd0, 8'd255, 1'b1);
		place(FN_ADD, 8'd0, 8'd255, 1'b0);
		place(FN_BUMP, 8'd255, 8'd255, 1'b0);
		// adjacent reference vertex leaves the count alone
		place(FN_BUMP, 8'd0, 8'd0, 1'b1);
		place(FN_DROP, 8'd255, 8'd0, 1'b0);
		place(FN_DROP, 8'd255, 8'd255, 1'b1);
		place(FN_REMOVE, 8'd0, 8'd255, 1'b0);
		place(FN_ADD, 8'd255, 8'd255, 1'b1);
		place(FN_CLEAR, 8'd255, 8'd0, 1'b1);
		// removal from an empty total floors at zero
		place(FN_REMOVE, 8'd0, 8'd255, 1'b0);
		place(FN_SPARE_LO, 8'd0, 8'd255, 1'b1);
		place(FN_SPARE_HI, 8'd255, 8'd0, 1'b0);
		set_limit(16'd1);
		place(FN_PAIR, 8'd0, 8'd255, 1'b0);
		place(FN_CHECK, 8'd255, 8'd0, 1'b0);
	endtask

	// count to its cap and back, total to its top and down to zero
	task automatic test_saturation();
		logic [7:0] v;
		logic [7:0] u;
		set_limit(TOTAL_MAX);
		v = 8'($urandom_range(1, 254));
		u = v ^ 8'h01;
		no_idle = $urandom_range(0, 1);
		place(FN_LOAD, v, ~v, 1'b0);
		place(FN_INIT, v, ~v, 1'b0);
		repeat (258) place(FN_BUMP, v, ~v, 1'($urandom_range(0, 1)));
		repeat (2) place(FN_DROP, v, ~v, 1'b0);
		repeat (3) place(FN_BUMP, v, ~v, 1'b1);
		place(FN_CLEAR, v, v, 1'b0);
		repeat (257) place(FN_ADD, pick_vertex(), v, 1'($urandom_range(0, 1)));
		// full total plus a full count must not fit even the widest limit
		place(FN_CHECK, v, u, 1'b0);
		place(FN_REMOVE, v, v, 1'b0);
		place(FN_CLEAR, v, v, 1'b1);
		place(FN_REMOVE, u, v, 1'b0);
		// count floor on a second vertex
		place(FN_LOAD, u, ~u, 1'b0);
		place(FN_INIT, u, ~u, 1'b1);
		repeat (3) place(FN_DROP, u, ~u, 1'b0);
		place(FN_BUMP, u, ~u, 1'b0);
		no_idle = 1'b0;
	endtask

	task automatic test_random_phase(logic [TOT_W-1:0] limit, int n, bit burst);
		set_limit(limit);
		no_idle = burst;
		repeat (n) random_word();
		no_idle = 1'b0;
	endtask

	// long output hold-off while words keep coming, then one word at a time
	task automatic test_backpressure();
		set_limit(16'($urandom_range(0, 40)));
		hold_off_req = 1'b1;
		no_idle      = 1'b1;
		repeat (30) random_word();
		no_idle = 1'b0;
		repeat (8) begin
			random_word();
			wait_drained();
		end
	endtask

	// result side: checks each accepted result word and drives out_stall
	initial begin : result_sink
		int   stall_left;
		int   r;
		logic nxt;
		due_t d;
		stall_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_stall === 1'b0) begin
				results_out++;
				if (due_results.size() == 0) begin
					faults++;
					$error("result word with nothing expected: %h", out_word);
				end else begin
					d = due_results.pop_front();
					if (out_word.fits !== d.word.fits)
						log_mismatch("fits", d.word.fits, out_word.fits);
					if (out_word.missing_total !== d.word.missing_total)
						log_mismatch("missing_total", d.word.missing_total,
							out_word.missing_total);
					if (d.count_known && out_word.vertex_count !== d.word.vertex_count)
						log_mismatch("vertex_count", d.word.vertex_count,
							out_word.vertex_count);
				end
			end
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				stall_left   = HOLD_OFF_CYCLES;
			end
			// stall pattern: runs of ready with short and occasional long stalls
			if (stall_left > 0) begin
				stall_left--;
				nxt = 1'b1;
			end else if (no_idle) begin
				nxt = 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 60) begin
					nxt = 1'b0;
				end else begin
					nxt        = 1'b1;
					stall_left = (r < 93) ? $urandom_range(0, 2) : $urandom_range(6, 30);
				end
			end
			out_stall <= nxt;
		end
	end

	// watchdog: too long with no word moving on either side ends the run
	initial begin : watchdog
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((in_valid === 1'b1 && in_stall === 1'b0) ||
			    (out_valid === 1'b1 && out_stall === 1'b0))
				quiet = 0;
			else
				quiet++;
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin : stimulus
		in_valid    <= 1'b0;
		in_word     <= '0;
		cfg_wr_en   <= 1'b0;
		cfg_wr_data <= '0;
		arst_n      <= 1'b0;
		vpool[0] = 8'd0;
		vpool[1] = 8'd255;
		for (int i = 2; i < 8; i++)
			vpool[i] = 8'($urandom_range(1, 254));
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_saturation();
		test_random_phase(16'd1, 130, 1'b0);
		test_random_phase(16'($urandom_range(2, 12)), 130, 1'b0);
		test_random_phase(16'($urandom_range(13, 65534)), 130, 1'b0);
		test_random_phase('0, 130, 1'b1);
		test_random_phase(TOTAL_MAX, 130, 1'b0);
		test_backpressure();

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (due_results.size() != 0) begin
			faults++;
			$error("%0d result words never arrived", due_results.size());
		end
		$display("covered %0d words in (%0d load, %0d add, %0d check, %0d pair), %0d results",
			words_in, func_tally[FN_LOAD], func_tally[FN_ADD], func_tally[FN_CHECK],
			func_tally[FN_PAIR], results_out);
		$display("limits from 0 to 65535, count and total saturation, output hold-off; %0d faults",
			faults);
		if (faults == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
